@@ hw/rtl/sacl_pkg.sv @@
package sacl_pkg;

   localparam int MAX_SET_BITS = 8;
   localparam int MAX_WAYS     = 8;
   localparam int ADDR_W       = 32;
   localparam int TAG_W        = 32;
   localparam int CNT_W        = 32;
   localparam int AGE_W        = 3;
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int SETS         = 1 << MAX_SET_BITS;
   localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // command codes
   localparam logic [1:0] CMD_MODIFY = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // outcome codes
   localparam logic [1:0] OUTCOME_HIT        = 2'd0;
   localparam logic [1:0] OUTCOME_MISS_FREE  = 2'd1;
   localparam logic [1:0] OUTCOME_MISS_EVICT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_WAYS       = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]       outcome;
      logic             extra_hit;
      logic [CNT_W-1:0] hits_total;
      logic [CNT_W-1:0] misses_total;
      logic [CNT_W-1:0] evictions_total;
   } rsp_type;

   // one set of the tag store
   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
      logic [MAX_WAYS-1:0][AGE_W-1:0] age;
   } row_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

@@ hw/rtl/set_assoc_cache_lru_sim_top.sv @@
// Tag store of a set-associative cache with true LRU replacement and saturating hit, miss
// and eviction counters. Each set lives in one row of an internal memory; a request reads the
// row, then one way-serial unit walks the ways in use (W = ways_in_use, clamped to 1..8) once
// to compare tags and find a free or oldest way, and once more to update the recency ranks;
// a modify walks them a third time for its guaranteed second hit. req_stall is high from the
// accept until the block is back in idle, so no new request is taken before the last one is
// through. The last step waits while an earlier result is still held in the output register.
// A cmd of 3 is taken in idle and gives no result. The result sits in an output register,
// so the next request is taken while it waits. Sets never written since reset read as empty
// through one flag per set, so no clearing pass is needed. Config writes are taken at any time
// (csr_ready is always high) and should only be issued while no request is in flight.
module set_assoc_cache_lru_sim_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sacl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sacl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [4:0]       csr_wdata
);
   import sacl_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_DECIDE = 6'b001000,
      S_TOUCH  = 6'b010000,
      S_WRITE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0] set_bits_ff;
   logic [3:0] ways_in_use_ff;
   logic [4:0] block_bits_ff;

   logic [3:0]        sb_eff;
   logic [SET_W:0]    set_mask_wide;
   logic [ADDR_W-1:0] addr_shifted;
   logic [5:0]        tag_shift;
   logic [SET_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;
   logic [WAY_W-1:0]  req_nw_m1;
   logic              req_fire;

   logic [WAY_W-1:0] idx_ff, idx_in;
   logic [WAY_W-1:0] nw_m1_ff, nw_m1_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [1:0]       cmd_ff, cmd_in;
   row_type          row_ff, row_in;

   logic             hit_found_ff, hit_found_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [AGE_W-1:0] hit_age_ff, hit_age_in;
   logic             free_found_ff, free_found_in;
   logic [WAY_W-1:0] free_way_ff, free_way_in;
   logic [AGE_W-1:0] max_age_ff, max_age_in;
   logic [WAY_W-1:0] max_way_ff, max_way_in;

   logic [WAY_W-1:0] way_ff, way_in;
   logic [AGE_W-1:0] old_age_ff, old_age_in;
   logic             pass2_ff, pass2_in;
   logic [1:0]       outcome_ff, outcome_in;
   logic             extra_ff, extra_in;

   logic [CNT_W-1:0] hits_ff, hits_in;
   logic [CNT_W-1:0] misses_ff, misses_in;
   logic [CNT_W-1:0] evicts_ff, evicts_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [SETS-1:0]  row_written_ff, row_written_in;
   row_type          rd_row_ff;
   logic             rd_written_ff;
   row_type          mem_array [SETS];

   // shared way unit operands
   logic             cur_valid;
   logic [TAG_W-1:0] cur_tag;
   logic [AGE_W-1:0] cur_age;
   logic             last_way;
   logic             bump;
   logic [WAY_W-1:0] way_sel;

   // address split
   always_comb begin
      sb_eff        = (set_bits_ff > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_ff;
      set_mask_wide = ({{SET_W{1'b0}}, 1'b1} << sb_eff) - {{SET_W{1'b0}}, 1'b1};
      addr_shifted  = req_data.address >> block_bits_ff;
      req_set       = addr_shifted[SET_W-1:0] & set_mask_wide[SET_W-1:0];
      tag_shift     = 6'(block_bits_ff) + 6'(sb_eff);
      req_tag       = req_data.address >> tag_shift;
      if (ways_in_use_ff == 4'd0) begin
         req_nw_m1 = '0;
      end else if (ways_in_use_ff > 4'(MAX_WAYS)) begin
         req_nw_m1 = WAY_W'(MAX_WAYS - 1);
      end else begin
         req_nw_m1 = WAY_W'(ways_in_use_ff - 4'd1);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur_valid = row_ff.valid[idx_ff];
   assign cur_tag   = row_ff.tag[idx_ff];
   assign cur_age   = row_ff.age[idx_ff];
   assign last_way  = (idx_ff == nw_m1_ff);
   assign bump      = (idx_ff != way_ff) && cur_valid && (cur_age <= old_age_ff)
                      && (cur_age != AGE_MAX);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      nw_m1_in       = nw_m1_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      cmd_in         = cmd_ff;
      row_in         = row_ff;
      hit_found_in   = hit_found_ff;
      hit_way_in     = hit_way_ff;
      hit_age_in     = hit_age_ff;
      free_found_in  = free_found_ff;
      free_way_in    = free_way_ff;
      max_age_in     = max_age_ff;
      max_way_in     = max_way_ff;
      way_in         = way_ff;
      old_age_in     = old_age_ff;
      pass2_in       = pass2_ff;
      outcome_in     = outcome_ff;
      extra_in       = extra_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      evicts_in      = evicts_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      row_written_in = row_written_ff;
      way_sel        = free_way_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.cmd != CMD_NONE)) begin
               set_in   = req_set;
               tag_in   = req_tag;
               cmd_in   = req_data.cmd;
               nw_m1_in = req_nw_m1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            row_in        = rd_row_ff;
            row_in.valid  = rd_written_ff ? rd_row_ff.valid : '0;
            idx_in        = '0;
            hit_found_in  = 1'b0;
            free_found_in = 1'b0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (!hit_found_ff && cur_valid && (cur_tag == tag_ff)) begin
               hit_found_in = 1'b1;
               hit_way_in   = idx_ff;
               hit_age_in   = cur_age;
            end
            if (!free_found_ff && !cur_valid) begin
               free_found_in = 1'b1;
               free_way_in   = idx_ff;
            end
            // oldest way, lowest number on a tie
            if ((idx_ff == '0) || (cur_age > max_age_ff)) begin
               max_age_in = cur_age;
               max_way_in = idx_ff;
            end
            if (last_way) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            pass2_in = 1'b0;
            extra_in = 1'b0;
            idx_in   = '0;
            if (hit_found_ff) begin
               way_in     = hit_way_ff;
               old_age_in = hit_age_ff;
               outcome_in = OUTCOME_HIT;
               hits_in    = sat_inc(hits_ff);
            end else begin
               misses_in = sat_inc(misses_ff);
               if (free_found_ff) begin
                  way_sel    = free_way_ff;
                  outcome_in = OUTCOME_MISS_FREE;
               end else begin
                  way_sel    = max_way_ff;
                  outcome_in = OUTCOME_MISS_EVICT;
                  evicts_in  = sat_inc(evicts_ff);
               end
               way_in                = way_sel;
               old_age_in            = AGE_MAX;
               row_in.valid[way_sel] = 1'b1;
               row_in.tag[way_sel]   = tag_ff;
            end
            state_in = S_TOUCH;
         end
         S_TOUCH: begin
            if (bump) begin
               row_in.age[idx_ff] = cur_age + 1'b1;
            end
            if (last_way) begin
               row_in.age[way_ff] = '0;
               idx_in             = '0;
               if ((cmd_ff == CMD_MODIFY) && !pass2_ff) begin
                  // second access of a modify hits the line just made most recent
                  pass2_in   = 1'b1;
                  old_age_in = '0;
                  extra_in   = 1'b1;
                  hits_in    = sat_inc(hits_ff);
               end else begin
                  state_in = S_WRITE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_WRITE: begin
            row_written_in[set_ff] = 1'b1;
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{outcome: outcome_ff, extra_hit: extra_ff,
                                hits_total: hits_ff, misses_total: misses_ff,
                                evictions_total: evicts_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         hits_ff        <= '0;
         misses_ff      <= '0;
         evicts_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         row_written_ff <= '0;
         set_bits_ff    <= 4'd0;
         ways_in_use_ff <= 4'd1;
         block_bits_ff  <= 5'd0;
      end else begin
         state_ff       <= state_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         evicts_ff      <= evicts_in;
         rsp_valid_ff   <= rsp_valid_in;
         row_written_ff <= row_written_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SET_BITS:   set_bits_ff    <= csr_wdata[3:0];
               CSR_WAYS:       ways_in_use_ff <= csr_wdata[3:0];
               CSR_BLOCK_BITS: block_bits_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      nw_m1_ff      <= nw_m1_in;
      set_ff        <= set_in;
      tag_ff        <= tag_in;
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      hit_found_ff  <= hit_found_in;
      hit_way_ff    <= hit_way_in;
      hit_age_ff    <= hit_age_in;
      free_found_ff <= free_found_in;
      free_way_ff   <= free_way_in;
      max_age_ff    <= max_age_in;
      max_way_ff    <= max_way_in;
      way_ff        <= way_in;
      old_age_ff    <= old_age_in;
      pass2_ff      <= pass2_in;
      outcome_ff    <= outcome_in;
      extra_ff      <= extra_in;
      rsp_data_ff   <= rsp_data_in;
      rd_written_ff <= row_written_ff[req_set];
   end

   // set memory, one row per set
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         mem_array[set_ff] <= row_ff;
      end
      rd_row_ff <= mem_array[req_set];
   end

   a_start_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.cmd != CMD_NONE)) |=> (state_ff == S_READ))
      else $error("accepted request did not start a set read");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) || (state_ff == S_TOUCH)) |-> (idx_ff <= nw_m1_ff))
      else $error("way index beyond ways in use");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DECIDE) && !hit_found_ff && !free_found_ff && (evicts_ff != CNT_MAX))
      |=> (evicts_ff == $past(evicts_ff) + 32'd1))
      else $error("eviction not counted");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WRITE) && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("result not loaded at end of item");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import sacl_pkg::*;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE = 40;
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_SET_BITS;
   logic [4:0] csr_wdata = '0;

   set_assoc_cache_lru_sim_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // mirror of the tag store, indexed set * MAX_WAYS + way
   bit               way_valid [SETS*MAX_WAYS];
   logic [TAG_W-1:0] way_tag   [SETS*MAX_WAYS];
   logic [AGE_W-1:0] way_rank  [SETS*MAX_WAYS];
   logic [CNT_W-1:0] hits_expect = '0;
   logic [CNT_W-1:0] misses_expect = '0;
   logic [CNT_W-1:0] evict_count = '0;
   int cfg_set_bits = 0;
   int cfg_ways = 1;
   int cfg_block_bits = 0;

   req_type access_q[$];
   rsp_type access_results_q[$];
   int items_sent = 0;
   int items_taken = 0;
   int results_seen = 0;
   int errors = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit long_hold_done = 1'b0;
   bit calm = 1'b0;
   logic next_valid;
   rsp_type want_rsp;

   function automatic logic [CNT_W-1:0] tally_up(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // make way w most recent; valid ways at least as recent as its old rank age by one
   function automatic void promote_way(input int base, input int nw, input int w,
                                       input logic [AGE_W-1:0] old_rank);
      int i;
      for (i = 0; i < nw; i++)
         if (i != w && way_valid[base+i] && way_rank[base+i] <= old_rank &&
             way_rank[base+i] < AGE_MAX)
            way_rank[base+i] = way_rank[base+i] + 1'b1;
      way_rank[base+w] = '0;
   endfunction

   function automatic void predict_access(input req_type item);
      int sbc, nw, base, way, i;
      logic [63:0] addr64;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] best;
      bit found;
      rsp_type r;
      if (item.cmd == CMD_NONE)
         return;
      r = '0;
      sbc = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
      nw = (cfg_ways == 0) ? 1 : cfg_ways;
      if (nw > MAX_WAYS)
         nw = MAX_WAYS;
      addr64 = {32'b0, item.address};
      base = int'((addr64 >> cfg_block_bits) & ((64'd1 << sbc) - 64'd1)) * MAX_WAYS;
      tag = TAG_W'(addr64 >> (cfg_block_bits + sbc));
      found = 1'b0;
      way = 0;
      for (i = 0; i < nw && !found; i++)
         if (way_valid[base+i] && way_tag[base+i] == tag) begin
            found = 1'b1;
            way = i;
         end
      if (found) begin
         r.outcome = OUTCOME_HIT;
         hits_expect = tally_up(hits_expect);
         promote_way(base, nw, way, way_rank[base+way]);
      end else begin
         misses_expect = tally_up(misses_expect);
         for (i = 0; i < nw && !found; i++)
            if (!way_valid[base+i]) begin
               found = 1'b1;
               way = i;
            end
         if (found) begin
            r.outcome = OUTCOME_MISS_FREE;
         end else begin
            // oldest way goes, lowest index wins a tie
            r.outcome = OUTCOME_MISS_EVICT;
            evict_count = tally_up(evict_count);
            way = 0;
            best = way_rank[base];
            for (i = 1; i < nw; i++)
               if (way_rank[base+i] > best) begin
                  best = way_rank[base+i];
                  way = i;
               end
         end
         way_valid[base+way] = 1'b1;
         way_tag[base+way] = tag;
         promote_way(base, nw, way, AGE_MAX);
      end
      if (item.cmd == CMD_MODIFY) begin
         r.extra_hit = 1'b1;
         hits_expect = tally_up(hits_expect);
         promote_way(base, nw, way, way_rank[base+way]);
      end
      r.hits_total = hits_expect;
      r.misses_total = misses_expect;
      r.evictions_total = evict_count;
      access_results_q.push_back(r);
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   // mostly a small pool of tags over a few sets so that hits and evictions happen
   function automatic req_type random_access(input int sb, input int ways, input int bb);
      req_type item;
      int sbc, nw, set_span, pick;
      logic [63:0] a;
      sbc = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
      nw = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
      pick = $urandom_range(0, 19);
      if (pick == 0)
         item.cmd = CMD_NONE;
      else if (pick < 8)
         item.cmd = CMD_LOAD;
      else if (pick < 14)
         item.cmd = CMD_STORE;
      else
         item.cmd = CMD_MODIFY;
      if ($urandom_range(0, 6) == 0) begin
         item.address = $urandom();
      end else begin
         set_span = ((1 << sbc) < 6) ? (1 << sbc) : 6;
         a = (64'($urandom_range(0, nw + 2)) << (bb + sbc)) |
             (64'($urandom_range(0, set_span - 1)) << bb) |
             (64'($urandom()) & ((64'd1 << bb) - 64'd1));
         item.address = a[31:0];
      end
      return item;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SET_BITS:   cfg_set_bits = val & 5'd15;
         CSR_WAYS:       cfg_ways = val & 5'd15;
         CSR_BLOCK_BITS: cfg_block_bits = val;
         default:        ;
      endcase
   endtask

   task automatic set_config(input int sb, input int ways, input int bb);
      write_reg(CSR_SET_BITS, 5'(sb));
      write_reg(CSR_WAYS, 5'(ways));
      write_reg(CSR_BLOCK_BITS, 5'(bb));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_access(input logic [1:0] cmd, input logic [31:0] address);
      req_type item;
      item.cmd = cmd;
      item.address = address;
      access_q.push_back(item);
      items_sent++;
   endtask

   // wait for every beat to be taken and answered, then for anything still in flight
   task automatic drain();
      do @(posedge clock);
      while (items_taken != items_sent || access_results_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            predict_access(req_data);
            items_taken++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (access_q.size() > 0) begin
               if (!calm && $urandom_range(0, 7) == 0) begin
                  gap_left = $urandom_range(0, 15);
               end else begin
                  req_data <= access_q.pop_front();
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // receiver back-pressure, with one long hold-off while beats keep coming
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0 && !calm) begin
            if (!long_hold_done && results_seen >= 200) begin
               long_hold_done = 1'b1;
               stall_left = LONG_HOLD;
            end else if ($urandom_range(0, 9) == 0) begin
               stall_left = $urandom_range(1, 16);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (access_results_q.size() == 0) begin
            $display("%0t: result with nothing outstanding: expected none, got %p",
                     $time, rsp_data);
            errors++;
         end else begin
            want_rsp = access_results_q.pop_front();
            check_field("outcome", 32'(want_rsp.outcome), 32'(rsp_data.outcome));
            check_field("extra_hit", 32'(want_rsp.extra_hit), 32'(rsp_data.extra_hit));
            check_field("hits_total", want_rsp.hits_total, rsp_data.hits_total);
            check_field("misses_total", want_rsp.misses_total, rsp_data.misses_total);
            check_field("evictions_total", want_rsp.evictions_total,
                        rsp_data.evictions_total);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int phase_cfg [8][4];
      int p, n;
      phase_cfg = '{'{2, 4, 4, 200}, '{8, 8, 0, 200}, '{0, 8, 6, 150}, '{3, 2, 24, 150},
                    '{5, 15, 31, 150}, '{15, 3, 12, 150}, '{1, 8, 16, 150},
                    '{4, 8, 2, 250}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fills, hit on modify, ignored command, eviction in the LRU order
      set_config(0, 4, 0);
      queue_access(CMD_LOAD, 32'h10);
      queue_access(CMD_LOAD, 32'h20);
      queue_access(CMD_STORE, 32'h30);
      queue_access(CMD_MODIFY, 32'h10);
      queue_access(CMD_NONE, 32'h10);
      queue_access(CMD_LOAD, 32'h40);
      queue_access(CMD_LOAD, 32'h50);
      queue_access(CMD_MODIFY, 32'h60);
      queue_access(CMD_STORE, 32'h50);
      drain();
      // shrink to one way so the same tag lands twice in one set
      set_config(0, 1, 0);
      queue_access(CMD_LOAD, 32'h40);
      drain();
      set_config(0, 4, 0);
      queue_access(CMD_LOAD, 32'h40);
      queue_access(CMD_MODIFY, 32'h0);
      drain();
      // out-of-range set and way counts, widest block offset
      set_config(15, 15, 31);
      queue_access(CMD_LOAD, 32'h8000_0000);
      queue_access(CMD_MODIFY, 32'hFFFF_FFFF);
      queue_access(CMD_LOAD, 32'h7FFF_FFFF);
      queue_access(CMD_NONE, 32'hFFFF_FFFF);
      drain();
      // zero ways behaves as one
      set_config(8, 0, 24);
      queue_access(CMD_LOAD, 32'hAB00_0000);
      queue_access(CMD_STORE, 32'hAB12_3456);
      queue_access(CMD_LOAD, 32'hAC00_0000);
      queue_access(CMD_LOAD, 32'h0000_0000);
      drain();

      for (p = 0; p < 8; p++) begin
         if (p == 7)
            calm <= 1'b1;
         set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
         for (n = 0; n < phase_cfg[p][3]; n++) begin
            access_q.push_back(random_access(phase_cfg[p][0], phase_cfg[p][1],
                                             phase_cfg[p][2]));
            items_sent++;
         end
         drain();
      end

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
